// ===== rtl/magstripe_track_f2f_encoder_macros.svh =====
// Assertion macros shared by the checker.
`ifndef MAGSTRIPE_TRACK_F2F_ENCODER_MACROS_SVH
`define MAGSTRIPE_TRACK_F2F_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checker: implication failed");

// Next-cycle implication, disabled while reset is asserted
`define MSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checker: next-cycle implication failed");

`endif

// ===== rtl/mse_pkg.sv =====
package mse_pkg;

  // Operation codes on the input channel
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_LOAD     = 3'd1;
  localparam logic [2:0] OP_PLAY_FWD = 3'd2;
  localparam logic [2:0] OP_PLAY_REV = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS      = 2'd2;

  // Register reset values and limits
  localparam logic [3:0] BPC_RESET    = 4'd5;
  localparam logic [3:0] BPC_MIN      = 4'd2;
  localparam logic [3:0] BPC_MAX      = 4'd8;
  localparam logic [6:0] OFFSET_RESET = 7'd48;
  localparam logic [7:0] PAD_RESET    = 8'd75;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_LOAD,
    K_PLAY,
    K_TICK
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       rev;
    logic [6:0] data;
    logic [7:0] coded;
  } cmd_t;

  typedef struct packed {
    logic [3:0] bpc;
    logic [7:0] pad_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  // Mask for the data bits of a character (bpc already clamped to 2..8)
  function automatic logic [6:0] data_mask(logic [3:0] bpc);
    return 7'h7F >> (BPC_MAX - bpc);
  endfunction

  // Clamp raw bits_per_char into 2..8
  function automatic logic [3:0] clamp_bpc(logic [3:0] raw);
    logic [3:0] res;
    res = raw;
    if (raw < BPC_MIN) res = BPC_MIN;
    else if (raw > BPC_MAX) res = BPC_MAX;
    return res;
  endfunction

  // Data bits with odd parity placed directly above them
  function automatic logic [7:0] code_char(logic [6:0] d_in, logic [3:0] bpc);
    logic [6:0] d;
    logic [7:0] par;
    d   = d_in & data_mask(bpc);
    par = 8'(~^d) << (bpc - 4'd1);
    return {1'b0, d} | par;
  endfunction

endpackage

// ===== rtl/mse_in_if.sv =====
interface mse_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] char_code;

  modport source (output valid, op, char_code, input ready);
  modport sink   (input valid, op, char_code, output ready);
endinterface

// ===== rtl/mse_out_if.sv =====
interface mse_out_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic first_half_level;
  logic second_half_level;
  logic driving;
  logic end_of_track;

  modport source (output valid, bit_value, first_half_level, second_half_level,
                  driving, end_of_track, input ready);
  modport sink   (input valid, bit_value, first_half_level, second_half_level,
                  driving, end_of_track, output ready);
endinterface

// ===== rtl/mse_cfg_if.sv =====
interface mse_cfg_if import mse_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mse_ram.sv =====
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mse_front.sv =====
module mse_front import mse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_ch,
  mse_cfg_if.sink    cfg_ch,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       queue_full,
  output cfg_t       cfg
);

  logic [3:0] bits_per_char_r;
  logic [6:0] char_offset_r;
  logic [7:0] pad_bits_r;
  logic [3:0] bpc;
  logic [7:0] diff;
  logic [6:0] data;
  logic       known;

  // Configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_per_char_r <= BPC_RESET;
      char_offset_r   <= OFFSET_RESET;
      pad_bits_r      <= PAD_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BITS_PER_CHAR: bits_per_char_r <= cfg_ch.data[3:0];
        REG_CHAR_OFFSET:   char_offset_r   <= cfg_ch.data[6:0];
        REG_PAD_BITS:      pad_bits_r      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign bpc          = clamp_bpc(bits_per_char_r);
  assign cfg.bpc      = bpc;
  assign cfg.pad_bits = pad_bits_r;

  // Offset removal and parity coding of a load
  assign diff = in_ch.char_code - {1'b0, char_offset_r};
  assign data = diff[6:0] & data_mask(bpc);

  // Classify the op; unknown ops are taken and dropped
  always_comb begin
    known          = 1'b1;
    push_cmd.kind  = K_TICK;
    push_cmd.rev   = 1'b0;
    push_cmd.data  = data;
    push_cmd.coded = code_char(data, bpc);
    case (in_ch.op)
      OP_CLEAR:    push_cmd.kind = K_CLEAR;
      OP_LOAD:     push_cmd.kind = K_LOAD;
      OP_PLAY_FWD: push_cmd.kind = K_PLAY;
      OP_PLAY_REV: begin
        push_cmd.kind = K_PLAY;
        push_cmd.rev  = 1'b1;
      end
      OP_TICK:     push_cmd.kind = K_TICK;
      default:     known = 1'b0;
    endcase
  end

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full && known;

endmodule

// ===== rtl/mse_queue.sv =====
module mse_queue import mse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   fill_r;

  assign full    = fill_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty   = fill_r == '0;
  assign pop_cmd = slot_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: ;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/mse_back.sv =====
module mse_back import mse_pkg::*; #(
  parameter int TRACK_CHARS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       empty,
  input  cmd_t       pop_cmd,
  output logic       pop,
  mse_out_if.source  out_ch
);

  localparam int AW = $clog2(TRACK_CHARS);
  localparam int CW = $clog2(TRACK_CHARS + 1);

  back_state_t state_r, state_nxt;
  cmd_t        cur_r;
  phase_t      phase_r, phase_nxt;
  logic        rev_r, rev_nxt;
  logic [CW-1:0] char_count_r, char_count_nxt;
  logic [CW-1:0] char_index_r, char_index_nxt;
  logic [6:0]  lrc_r, lrc_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  pad_count_r, pad_count_nxt;
  logic        level_r, level_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_bit_r, out_bit_nxt;
  logic out_first_r, out_first_nxt;
  logic out_second_r, out_second_nxt;
  logic out_drv_r, out_drv_nxt;
  logic out_eot_r, out_eot_nxt;

  logic          stall;
  logic          exec_go;
  logic          store_full;
  logic          ram_we;
  logic [CW-1:0] rd_idx;
  logic [7:0]    ram_rdata;

  // Tick datapath
  logic          is_lrc;
  logic [7:0]    cur_char;
  logic [3:0]    j4;
  logic [3:0]    pos4;
  logic          bit_val;
  logic          first_lvl;
  logic          second_lvl;
  logic [3:0]    bit_inc;
  logic [8:0]    pad_inc;

  assign store_full = char_count_r == CW'(TRACK_CHARS);
  assign stall      = (cur_r.kind == K_TICK) && out_valid_r && !out_ch.ready;

  // Store read follows the play position; data arrives in the execute cycle
  assign rd_idx = rev_r ? (char_count_r - char_index_r) : char_index_r;

  mse_ram #(.WIDTH(8), .DEPTH(TRACK_CHARS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (char_count_r[AW-1:0]),
    .wdata (cur_r.coded),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_FETCH: if (!empty) state_nxt = BK_EXEC;
      BK_EXEC:  if (!stall) state_nxt = BK_FETCH;
      default:  state_nxt = BK_FETCH;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop     = 1'b0;
    exec_go = 1'b0;
    case (state_r)
      BK_FETCH: pop     = !empty;
      BK_EXEC:  exec_go = !stall;
      default: ;
    endcase
  end

  // Cell bit and line levels
  always_comb begin
    if (rev_r) is_lrc = (char_index_r == '0) || (char_index_r > char_count_r);
    else       is_lrc = char_index_r >= char_count_r;
    cur_char = is_lrc ? code_char(lrc_r, cfg.bpc) : ram_rdata;
    j4       = {1'b0, bit_index_r};
    if (!rev_r)          pos4 = j4;
    else if (j4 < cfg.bpc) pos4 = cfg.bpc - 4'd1 - j4;
    else                 pos4 = 4'd0;
    bit_val    = (phase_r == PH_DATA) && cur_char[pos4[2:0]];
    first_lvl  = !level_r;
    second_lvl = first_lvl ^ bit_val;
    bit_inc    = j4 + 4'd1;
    pad_inc    = {1'b0, pad_count_r} + 9'd1;
  end

  // Command execution
  always_comb begin
    phase_nxt      = phase_r;
    rev_nxt        = rev_r;
    char_count_nxt = char_count_r;
    char_index_nxt = char_index_r;
    lrc_nxt        = lrc_r;
    bit_index_nxt  = bit_index_r;
    pad_count_nxt  = pad_count_r;
    level_nxt      = level_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_bit_nxt    = out_bit_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_drv_nxt    = out_drv_r;
    out_eot_nxt    = out_eot_r;
    if (exec_go) begin
      case (cur_r.kind)
        K_CLEAR: begin
          char_count_nxt = '0;
          lrc_nxt        = '0;
          phase_nxt      = PH_IDLE;
        end
        K_LOAD: begin
          if (phase_r == PH_IDLE && !store_full) begin
            ram_we         = 1'b1;
            char_count_nxt = char_count_r + 1'b1;
            lrc_nxt        = lrc_r ^ cur_r.data;
          end
        end
        K_PLAY: begin
          rev_nxt        = cur_r.rev;
          level_nxt      = 1'b0;
          char_index_nxt = '0;
          bit_index_nxt  = '0;
          pad_count_nxt  = '0;
          phase_nxt      = (cfg.pad_bits == '0) ? PH_DATA : PH_LEAD;
        end
        K_TICK: begin
          out_valid_nxt  = 1'b1;
          out_bit_nxt    = 1'b0;
          out_first_nxt  = 1'b0;
          out_second_nxt = 1'b0;
          out_drv_nxt    = 1'b0;
          out_eot_nxt    = 1'b0;
          if (phase_r != PH_IDLE) begin
            out_bit_nxt    = bit_val;
            out_first_nxt  = first_lvl;
            out_second_nxt = second_lvl;
            out_drv_nxt    = 1'b1;
            level_nxt      = second_lvl;
            case (phase_r)
              PH_DATA: begin
                bit_index_nxt = bit_inc[2:0];
                if (bit_inc >= cfg.bpc) begin
                  bit_index_nxt = '0;
                  if (char_index_r >= char_count_r) begin
                    pad_count_nxt = '0;
                    if (cfg.pad_bits == '0) begin
                      out_eot_nxt = 1'b1;
                      phase_nxt   = PH_IDLE;
                    end else begin
                      phase_nxt = PH_TRAIL;
                    end
                  end else begin
                    char_index_nxt = char_index_r + 1'b1;
                  end
                end
              end
              PH_LEAD, PH_TRAIL: begin
                pad_count_nxt = pad_inc[7:0];
                if (pad_inc >= {1'b0, cfg.pad_bits}) begin
                  pad_count_nxt = '0;
                  if (phase_r == PH_LEAD) begin
                    phase_nxt = PH_DATA;
                  end else begin
                    out_eot_nxt = 1'b1;
                    phase_nxt   = PH_IDLE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Control and play state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_FETCH;
      phase_r      <= PH_IDLE;
      rev_r        <= 1'b0;
      char_count_r <= '0;
      char_index_r <= '0;
      lrc_r        <= '0;
      bit_index_r  <= '0;
      pad_count_r  <= '0;
      level_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      rev_r        <= rev_nxt;
      char_count_r <= char_count_nxt;
      char_index_r <= char_index_nxt;
      lrc_r        <= lrc_nxt;
      bit_index_r  <= bit_index_nxt;
      pad_count_r  <= pad_count_nxt;
      level_r      <= level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Command holding and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_cmd;
    end
    out_bit_r    <= out_bit_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_drv_r    <= out_drv_nxt;
    out_eot_r    <= out_eot_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.bit_value         = out_bit_r;
  assign out_ch.first_half_level  = out_first_r;
  assign out_ch.second_half_level = out_second_r;
  assign out_ch.driving           = out_drv_r;
  assign out_ch.end_of_track      = out_eot_r;

endmodule

// ===== rtl/magstripe_track_f2f_encoder.sv =====
// Magnetic stripe track player with F2F (Aiken biphase) line coding.
// Input channel in_ch carries op and char_code: clear, load a character,
// play forward, play reverse, or tick. Each tick returns exactly one
// transaction on out_ch (one bit cell: bit, two half-cell coil levels,
// driving, end_of_track); other ops return nothing. cfg_ch writes
// bits_per_char, char_offset and pad_bits by index and is always ready.
// A front stage classifies and codes each transaction into a two-entry
// command queue; the back sequencer runs each command through a fetch
// state that reads the track store (registered read) and an execute state,
// and takes no new command until the last is done. An accepted tick passes
// the queue slot, the fetch state and the execute state before its result
// reaches out_ch. The result sits in an output register: while out_ch is
// stalled the back holds a waiting tick, the queue fills and in_ch drops
// ready after two more transactions. Reset sets the registers to 5, 48 and
// 75, empties the store and the queue and leaves the player idle; the store
// needs no clearing pass: only entries below the character count are used.
module magstripe_track_f2f_encoder import mse_pkg::*; #(
  parameter int TRACK_CHARS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_ch,
  mse_out_if.source  out_ch,
  mse_cfg_if.sink    cfg_ch
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  cmd_t pop_cmd;
  logic queue_empty;
  cfg_t cfg;

  mse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full),
    .cfg        (cfg)
  );

  mse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  mse_back #(.TRACK_CHARS(TRACK_CHARS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .empty   (queue_empty),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/mse_chk.sv =====
`include "magstripe_track_f2f_encoder_macros.svh"

module mse_chk (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic bit_value,
  input logic first_half_level,
  input logic second_half_level,
  input logic driving,
  input logic end_of_track
);

  // A stalled result holds
  `MSE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bit_value) && $stable(first_half_level))

  // Idle cells keep both coils low and carry no bit
  `MSE_ASSERT_IMP(a_idle_quiet, clk, rst_n, out_valid && !driving, !bit_value && !first_half_level && !second_half_level && !end_of_track)

  // F2F: a mid-cell transition exactly when the bit is one
  `MSE_ASSERT_IMP(a_f2f_mid, clk, rst_n, out_valid && driving, (first_half_level ^ second_half_level) == bit_value)

  // End of track only on a driven cell
  `MSE_ASSERT_IMP(a_eot_driving, clk, rst_n, out_valid && end_of_track, driving)

endmodule

bind magstripe_track_f2f_encoder mse_chk u_mse_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .bit_value         (out_ch.bit_value),
  .first_half_level  (out_ch.first_half_level),
  .second_half_level (out_ch.second_half_level),
  .driving           (out_ch.driving),
  .end_of_track      (out_ch.end_of_track)
);
